// ----- rtl/mtrsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MCU-to-raster strip buffer package
// Shared constants, codes and types of the strip buffer.
// ----------------------------------------------------------------------------
package mtrsb_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int MAX_WIDTH_DEF        = 1024;
   localparam int MAX_BLOCK_HEIGHT_DEF = 16;
   localparam int BANKS_DEF            = 2;

   // Fixed field widths.
   localparam int PIXEL_W     = 24;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int BLOCK_COL_W = 4;
   localparam int MCU_WIDTH_W = 5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MCU_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MCU_HEIGHT  = 2'd2;

   // Reset values and limits of the configuration registers.
   localparam int IMAGE_WIDTH_RST = 8;
   localparam int MCU_WIDTH_RST   = 8;
   localparam int MCU_HEIGHT_RST  = 8;
   localparam int MCU_WIDTH_MAX   = 16;

   // Command and result codes.
   localparam logic CMD_STORE  = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DROP  = 1'b1;

   // Byte extraction of a packed pixel.
   localparam logic [7:0] BYTE_MASK   = 8'hFF;
   localparam int         RED_SHIFT   = 16;
   localparam int         GREEN_SHIFT = 8;

   // Drain position realignment sequencer.
   typedef enum logic [2:0] {
      ALIGN_IDLE,
      ALIGN_TOTAL,
      ALIGN_SAT,
      ALIGN_DIV,
      ALIGN_DONE
   } align_state_type;

   typedef struct packed {
      logic busy;
      logic load;
   } align_status_type;

   typedef struct packed {
      logic valid;
      logic kind;
      logic last;
   } result_type;

endpackage

// ----- rtl/mtrsb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip buffer request channel
// Valid/ready channel that carries one command and its pixel.
// ----------------------------------------------------------------------------
interface mtrsb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [mtrsb_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output command, output pixel, input ready);
   modport sink   (input valid, input command, input pixel, output ready);
endinterface

// ----- rtl/mtrsb_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip buffer response channel
// Valid/ready channel that carries one delivered strip pixel or a drop flag.
// ----------------------------------------------------------------------------
interface mtrsb_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_of_strip;

   modport source (output valid, output kind, output red, output green, output blue,
                   output last_of_strip, input ready);
   modport sink   (input valid, input kind, input red, input green, input blue,
                   input last_of_strip, output ready);
endinterface

// ----- rtl/mtrsb_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip buffer configuration
// Holds the saturated configuration registers, the strip size, and a small
// sequencer that maps the raster drain index to a strip row and column
// after reset and after every configuration write.
// ----------------------------------------------------------------------------
module mtrsb_cfg #(
   parameter int MAX_WIDTH        = mtrsb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BLOCK_HEIGHT = mtrsb_pkg::MAX_BLOCK_HEIGHT_DEF,
   localparam int IWW = $clog2(MAX_WIDTH + 1),
   localparam int MHW = $clog2(MAX_BLOCK_HEIGHT + 1),
   localparam int RW  = (MAX_BLOCK_HEIGHT > 1) ? $clog2(MAX_BLOCK_HEIGHT) : 1,
   localparam int CLW = $clog2(MAX_WIDTH),
   localparam int TW  = IWW + MHW,
   localparam int IXW = $clog2(MAX_WIDTH * MAX_BLOCK_HEIGHT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mtrsb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mtrsb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [IXW-1:0]                      drain_idx,
   output logic [IWW-1:0]                      iw,
   output logic [mtrsb_pkg::MCU_WIDTH_W-1:0]   mw,
   output logic [MHW-1:0]                      mh,
   output logic [TW-1:0]                       total,
   output logic [RW-1:0]                       align_row,
   output logic [CLW-1:0]                      align_col,
   output mtrsb_pkg::align_status_type         align_status
);

   localparam int SCW = (RW > 1) ? $clog2(RW) : 1;
   localparam int MH_RST = (mtrsb_pkg::MCU_HEIGHT_RST < MAX_BLOCK_HEIGHT) ?
                           mtrsb_pkg::MCU_HEIGHT_RST : MAX_BLOCK_HEIGHT;

   logic [IWW-1:0]                    iw_ff;
   logic [mtrsb_pkg::MCU_WIDTH_W-1:0] mw_ff;
   logic [MHW-1:0]                    mh_ff;
   logic [TW-1:0]                     total_ff;
   logic [TW-1:0]                     rem_ff;
   logic [TW-1:0]                     dvs_ff;
   logic [RW-1:0]                     quo_ff;
   logic [SCW-1:0]                    step_ff;
   mtrsb_pkg::align_state_type        state_ff;
   mtrsb_pkg::align_state_type        state_in;

   logic [31:0]                       wdata32;
   logic [31:0]                       wsmall32;
   logic [IWW-1:0]                    iw_clamp;
   logic [mtrsb_pkg::MCU_WIDTH_W-1:0] mw_clamp;
   logic [MHW-1:0]                    mh_clamp;
   logic [TW-1:0]                     eff_idx;
   logic                              rem_ge;

   // Saturate the written values into their legal ranges.
   always_comb begin
      wdata32  = 32'(csr_wdata);
      wsmall32 = 32'(csr_wdata[mtrsb_pkg::MCU_WIDTH_W-1:0]);
      if (wdata32 == 32'd0) begin
         iw_clamp = IWW'(1);
      end else if (wdata32 > 32'(MAX_WIDTH)) begin
         iw_clamp = IWW'(MAX_WIDTH);
      end else begin
         iw_clamp = IWW'(wdata32);
      end
      if (wsmall32 == 32'd0) begin
         mw_clamp = mtrsb_pkg::MCU_WIDTH_W'(1);
      end else if (wsmall32 > 32'(mtrsb_pkg::MCU_WIDTH_MAX)) begin
         mw_clamp = mtrsb_pkg::MCU_WIDTH_W'(mtrsb_pkg::MCU_WIDTH_MAX);
      end else begin
         mw_clamp = mtrsb_pkg::MCU_WIDTH_W'(wsmall32);
      end
      if (wsmall32 == 32'd0) begin
         mh_clamp = MHW'(1);
      end else if (wsmall32 > 32'(MAX_BLOCK_HEIGHT)) begin
         mh_clamp = MHW'(MAX_BLOCK_HEIGHT);
      end else begin
         mh_clamp = MHW'(wsmall32);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= IWW'(mtrsb_pkg::IMAGE_WIDTH_RST);
         mw_ff <= mtrsb_pkg::MCU_WIDTH_W'(mtrsb_pkg::MCU_WIDTH_RST);
         mh_ff <= MHW'(MH_RST);
      end else if (csr_we) begin
         unique case (csr_index)
            mtrsb_pkg::CSR_IMAGE_WIDTH: iw_ff <= iw_clamp;
            mtrsb_pkg::CSR_MCU_WIDTH:   mw_ff <= mw_clamp;
            mtrsb_pkg::CSR_MCU_HEIGHT:  mh_ff <= mh_clamp;
            default: ;
         endcase
      end
   end

   // Sequencer next state: any write restarts the realignment.
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = mtrsb_pkg::ALIGN_TOTAL;
      end else begin
         unique case (state_ff)
            mtrsb_pkg::ALIGN_IDLE:  state_in = mtrsb_pkg::ALIGN_IDLE;
            mtrsb_pkg::ALIGN_TOTAL: state_in = mtrsb_pkg::ALIGN_SAT;
            mtrsb_pkg::ALIGN_SAT:   state_in = mtrsb_pkg::ALIGN_DIV;
            mtrsb_pkg::ALIGN_DIV: begin
               if (step_ff == SCW'(0)) begin
                  state_in = mtrsb_pkg::ALIGN_DONE;
               end
            end
            mtrsb_pkg::ALIGN_DONE:  state_in = mtrsb_pkg::ALIGN_IDLE;
            default:                state_in = mtrsb_pkg::ALIGN_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtrsb_pkg::ALIGN_TOTAL;
      end else begin
         state_ff <= state_in;
      end
   end

   // The drain index saturates to the last pixel of a smaller strip.
   always_comb begin
      if (TW'(drain_idx) < total_ff) begin
         eff_idx = TW'(drain_idx);
      end else begin
         eff_idx = total_ff - TW'(1);
      end
      rem_ge = (rem_ff >= dvs_ff);
   end

   // Restoring division of the drain index by the row length, one
   // quotient bit per cycle.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         mtrsb_pkg::ALIGN_TOTAL: begin
            total_ff <= TW'(iw_ff) * TW'(mh_ff);
         end
         mtrsb_pkg::ALIGN_SAT: begin
            rem_ff  <= eff_idx;
            dvs_ff  <= TW'(iw_ff) << (RW - 1);
            quo_ff  <= '0;
            step_ff <= SCW'(RW - 1);
         end
         mtrsb_pkg::ALIGN_DIV: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            quo_ff  <= (quo_ff << 1) | RW'(rem_ge);
            dvs_ff  <= dvs_ff >> 1;
            step_ff <= step_ff - SCW'(1);
         end
         default: ;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      align_status.busy = (state_ff != mtrsb_pkg::ALIGN_IDLE);
      align_status.load = (state_ff == mtrsb_pkg::ALIGN_DONE);
   end

   assign iw        = iw_ff;
   assign mw        = mw_ff;
   assign mh        = mh_ff;
   assign total     = total_ff;
   assign align_row = quo_ff;
   assign align_col = CLW'(rem_ff);

endmodule

// ----- rtl/mtrsb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip buffer bank control
// Tracks the block write position, the strip drain position and the bank
// hand-over, and produces the strip memory accesses of each transaction.
// ----------------------------------------------------------------------------
module mtrsb_ctrl #(
   parameter int MAX_WIDTH        = mtrsb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BLOCK_HEIGHT = mtrsb_pkg::MAX_BLOCK_HEIGHT_DEF,
   parameter int BANKS            = mtrsb_pkg::BANKS_DEF,
   localparam int IWW = $clog2(MAX_WIDTH + 1),
   localparam int MHW = $clog2(MAX_BLOCK_HEIGHT + 1),
   localparam int RW  = (MAX_BLOCK_HEIGHT > 1) ? $clog2(MAX_BLOCK_HEIGHT) : 1,
   localparam int CLW = $clog2(MAX_WIDTH),
   localparam int TW  = IWW + MHW,
   localparam int IXW = $clog2(MAX_WIDTH * MAX_BLOCK_HEIGHT),
   localparam int BKW = (BANKS > 1) ? $clog2(BANKS) : 1,
   localparam int AW  = BKW + RW + CLW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                command,
   input  logic [IWW-1:0]                      iw,
   input  logic [mtrsb_pkg::MCU_WIDTH_W-1:0]   mw,
   input  logic [MHW-1:0]                      mh,
   input  logic [TW-1:0]                       total,
   input  logic [RW-1:0]                       align_row,
   input  logic [CLW-1:0]                      align_col,
   input  mtrsb_pkg::align_status_type         align_status,
   output logic [IXW-1:0]                      drain_idx,
   output logic                                mem_we,
   output logic [AW-1:0]                       mem_waddr,
   output logic                                mem_re,
   output logic [AW-1:0]                       mem_raddr,
   output mtrsb_pkg::result_type               result
);

   localparam int BFW = $clog2(BANKS + 1);
   localparam int SW  = $clog2(MAX_WIDTH + mtrsb_pkg::MCU_WIDTH_MAX);
   localparam int BCW = mtrsb_pkg::BLOCK_COL_W;

   logic [BKW-1:0] wbank_ff;
   logic [BKW-1:0] dbank_ff;
   logic [BFW-1:0] bfull_ff;
   logic [RW-1:0]  brow_ff;
   logic [BCW-1:0] bcol_ff;
   logic [CLW-1:0] base_ff;
   logic [IXW-1:0] didx_ff;
   logic [RW-1:0]  drow_ff;
   logic [CLW-1:0] dcol_ff;

   logic           full;
   logic           have;
   logic           store_ok;
   logic           drain_ok;
   logic [SW-1:0]  col_sum;
   logic [BCW:0]   bc1;
   logic [RW:0]    br1;
   logic [SW-1:0]  nb;
   logic           wrap_col;
   logic           wrap_row;
   logic           wrap_base;
   logic           last;
   logic [TW-1:0]  eff_idx;
   logic [BKW-1:0] wbank_next;
   logic [BKW-1:0] dbank_next;

   // Bank state and the two positions.
   always_comb begin
      full     = (bfull_ff == BFW'(BANKS));
      have     = (bfull_ff != BFW'(0));
      store_ok = accept && (command == mtrsb_pkg::CMD_STORE) && !full;
      drain_ok = accept && (command == mtrsb_pkg::CMD_DRAIN) && have;

      wbank_next = (32'(wbank_ff) + 32'd1 >= 32'(BANKS)) ? '0 : wbank_ff + BKW'(1);
      dbank_next = (32'(dbank_ff) + 32'd1 >= 32'(BANKS)) ? '0 : dbank_ff + BKW'(1);
   end

   // Write side: strip column of the current block pixel, crop and advance.
   always_comb begin
      col_sum   = SW'(base_ff) + SW'(bcol_ff);
      bc1       = (BCW + 1)'(bcol_ff) + (BCW + 1)'(1);
      br1       = (RW + 1)'(brow_ff) + (RW + 1)'(1);
      nb        = SW'(base_ff) + SW'(mw);
      wrap_col  = (32'(bc1) >= 32'(mw));
      wrap_row  = (32'(br1) >= 32'(mh));
      wrap_base = (32'(nb) >= 32'(iw));

      mem_we    = store_ok && (32'(brow_ff) < 32'(mh)) && (32'(bcol_ff) < 32'(mw)) &&
                  (32'(col_sum) < 32'(iw));
      mem_waddr = {wbank_ff, brow_ff, col_sum[CLW-1:0]};
   end

   // Drain side: raster read of the completed strip.
   always_comb begin
      last      = (32'(drow_ff) == 32'(mh) - 32'd1) && (32'(dcol_ff) == 32'(iw) - 32'd1);
      eff_idx   = (TW'(didx_ff) < total) ? TW'(didx_ff) : total - TW'(1);
      mem_re    = drain_ok;
      mem_raddr = {dbank_ff, drow_ff, dcol_ff};

      result.valid = (accept && (command == mtrsb_pkg::CMD_STORE) && full) || drain_ok;
      result.kind  = (command == mtrsb_pkg::CMD_STORE) ? mtrsb_pkg::KIND_DROP :
                                                         mtrsb_pkg::KIND_PIXEL;
      result.last  = drain_ok && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wbank_ff <= '0;
         dbank_ff <= '0;
         bfull_ff <= '0;
         brow_ff  <= '0;
         bcol_ff  <= '0;
         base_ff  <= '0;
         didx_ff  <= '0;
         drow_ff  <= '0;
         dcol_ff  <= '0;
      end else begin
         // Drain position as mapped from the index under the new configuration.
         if (align_status.load) begin
            drow_ff <= align_row;
            dcol_ff <= align_col;
         end

         // Block position, column base and hand-over of a finished strip.
         if (store_ok) begin
            bcol_ff <= wrap_col ? '0 : bc1[BCW-1:0];
            if (wrap_col) begin
               brow_ff <= wrap_row ? '0 : br1[RW-1:0];
               if (wrap_row) begin
                  base_ff <= wrap_base ? '0 : nb[CLW-1:0];
                  if (wrap_base) begin
                     bfull_ff <= bfull_ff + BFW'(1);
                     wbank_ff <= wbank_next;
                  end
               end
            end
         end

         // Drain position and release of a fully read strip.
         if (drain_ok) begin
            if (last) begin
               didx_ff  <= '0;
               drow_ff  <= '0;
               dcol_ff  <= '0;
               bfull_ff <= bfull_ff - BFW'(1);
               dbank_ff <= dbank_next;
            end else begin
               didx_ff <= IXW'(eff_idx + TW'(1));
               if (32'(dcol_ff) == 32'(iw) - 32'd1) begin
                  dcol_ff <= '0;
                  drow_ff <= drow_ff + RW'(1);
               end else begin
                  dcol_ff <= dcol_ff + CLW'(1);
               end
            end
         end
      end
   end

   assign drain_idx = didx_ff;

endmodule

// ----- rtl/mtrsb_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip buffer pixel memory
// Banked strip storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtrsb_store #(
   parameter int AW = 15
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [AW-1:0]                 waddr,
   input  logic [mtrsb_pkg::PIXEL_W-1:0] wdata,
   input  logic                          re,
   input  logic [AW-1:0]                 raddr,
   output logic [mtrsb_pkg::PIXEL_W-1:0] rdata
);

   logic [mtrsb_pkg::PIXEL_W-1:0] mem [2**AW];
   logic [mtrsb_pkg::PIXEL_W-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/mcu_to_raster_strip_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MCU-to-raster strip buffer
// Stores decoded block pixels into banked strips one block high and reads
// completed strips back in raster order.
//
//   Channel  Direction  Payload                                  Accepted when
//   req      in         command, pixel                           valid && ready
//   rsp      out        kind, red, green, blue, last_of_strip    valid && ready
//   csr      in         index, write data                        csr_we
//
// One transaction is accepted per cycle while ready is high; its result, if
// any, sits in the output register in the next cycle, as the strip memory
// read is registered. After reset and after every configuration write,
// ready stays low while a one-bit-per-cycle divider maps the drain index to a
// strip row and column. A stalled result holds its register and ready follows
// rsp ready; the strip memory has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module mcu_to_raster_strip_buffer #(
   parameter int MAX_WIDTH        = mtrsb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BLOCK_HEIGHT = mtrsb_pkg::MAX_BLOCK_HEIGHT_DEF,
   parameter int BANKS            = mtrsb_pkg::BANKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   mtrsb_req_if.sink                         req_chan,
   mtrsb_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [mtrsb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mtrsb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IWW = $clog2(MAX_WIDTH + 1);
   localparam int MHW = $clog2(MAX_BLOCK_HEIGHT + 1);
   localparam int RW  = (MAX_BLOCK_HEIGHT > 1) ? $clog2(MAX_BLOCK_HEIGHT) : 1;
   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int TW  = IWW + MHW;
   localparam int IXW = $clog2(MAX_WIDTH * MAX_BLOCK_HEIGHT);
   localparam int BKW = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int AW  = BKW + RW + CLW;

   logic [IWW-1:0]                    iw;
   logic [mtrsb_pkg::MCU_WIDTH_W-1:0] mw;
   logic [MHW-1:0]                    mh;
   logic [TW-1:0]                     total;
   logic [RW-1:0]                     align_row;
   logic [CLW-1:0]                    align_col;
   mtrsb_pkg::align_status_type       align_status;
   logic [IXW-1:0]                    drain_idx;
   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   logic                              mem_re;
   logic [AW-1:0]                     mem_raddr;
   logic [mtrsb_pkg::PIXEL_W-1:0]     rdata;
   mtrsb_pkg::result_type             result;

   logic                              req_accept;
   logic                              rsp_valid_ff;
   logic                              rsp_kind_ff;
   logic                              rsp_last_ff;
   logic [mtrsb_pkg::PIXEL_W-1:0]     pix_out;

   mtrsb_cfg #(
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_BLOCK_HEIGHT (MAX_BLOCK_HEIGHT)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .drain_idx    (drain_idx),
      .iw           (iw),
      .mw           (mw),
      .mh           (mh),
      .total        (total),
      .align_row    (align_row),
      .align_col    (align_col),
      .align_status (align_status)
   );

   mtrsb_ctrl #(
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_BLOCK_HEIGHT (MAX_BLOCK_HEIGHT),
      .BANKS            (BANKS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .command      (req_chan.command),
      .iw           (iw),
      .mw           (mw),
      .mh           (mh),
      .total        (total),
      .align_row    (align_row),
      .align_col    (align_col),
      .align_status (align_status),
      .drain_idx    (drain_idx),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .result       (result)
   );

   mtrsb_store #(
      .AW (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (req_chan.pixel),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rdata)
   );

   // Input handshake: blocked only by realignment or a stalled result.
   assign req_chan.ready = !align_status.busy && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Result register; the pixel data sits in the memory read register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result.valid) begin
         rsp_kind_ff <= result.kind;
         rsp_last_ff <= result.last;
      end
   end

   // A dropped pixel reports all-zero color fields.
   assign pix_out = (rsp_kind_ff == mtrsb_pkg::KIND_DROP) ? '0 : rdata;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.red           = 8'(pix_out >> mtrsb_pkg::RED_SHIFT) & mtrsb_pkg::BYTE_MASK;
   assign rsp_chan.green         = 8'(pix_out >> mtrsb_pkg::GREEN_SHIFT) & mtrsb_pkg::BYTE_MASK;
   assign rsp_chan.blue          = 8'(pix_out) & mtrsb_pkg::BYTE_MASK;
   assign rsp_chan.last_of_strip = rsp_last_ff;

   // No transaction is taken while the drain position is being remapped.
   assert property (@(posedge clock) disable iff (reset)
      align_status.busy |-> !req_accept)
      else $error("request accepted during drain realignment");

   // A configuration write always starts a realignment.
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> align_status.busy)
      else $error("configuration write did not start realignment");

   // Every accepted transaction with a result shows it in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && result.valid |=> rsp_chan.valid)
      else $error("result of an accepted transaction was lost");

   // A drop report carries no pixel and no end-of-strip flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind == mtrsb_pkg::KIND_DROP) |->
         (rsp_chan.red == 8'd0) && (rsp_chan.green == 8'd0) &&
         (rsp_chan.blue == 8'd0) && !rsp_chan.last_of_strip)
      else $error("drop report carries pixel data");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MCU-to-raster strip buffer testbench
// Drives block pixels and drain requests into the strip buffer, predicts every
// delivered strip pixel and drop flag with a behavioral copy of the buffer, and
// compares the response channel against it. A short stimulus table covers the
// reset state, both full banks, drops, cropping and register changes in the
// middle of a strip. Phases of random whole strips follow under several
// register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
   import mtrsb_pkg::*;

   localparam int          BANK_WORDS    = MAX_WIDTH_DEF * MAX_BLOCK_HEIGHT_DEF;
   localparam int          STORE_AW      = $clog2(BANKS_DEF * BANK_WORDS);
   localparam int          SETTLE_CYCLES = 24;
   localparam int          ITEM_TARGET   = 1350;
   localparam int unsigned TIMEOUT_NS    = 4_000_000;
   localparam int          END_WAIT_MAX  = 20_000;

   typedef enum {ROW_CSR, ROW_ITEM, ROW_ITEM_TYPED, ROW_ITEM_NONE} row_kind_type;
   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } strip_result_type;

   typedef struct {
      row_kind_type            how;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   value;
      logic                    command;
      logic [PIXEL_W-1:0]      pixel;
      strip_result_type        typed;
   } stim_row_type;

   localparam strip_result_type NO_RESULT   = '0;
   localparam strip_result_type DROP_RESULT = '{KIND_DROP, 8'h00, 8'h00, 8'h00, 1'b0};

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mtrsb_req_if req_chan();
   mtrsb_rsp_if rsp_chan();

   mcu_to_raster_strip_buffer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted buffer state and its register copies.
   logic [PIXEL_W-1:0]     strip_mem [0:BANKS_DEF*BANK_WORDS-1];
   logic [CSR_DATA_W-1:0]  cfg_image_width;
   logic [MCU_WIDTH_W-1:0] cfg_mcu_width;
   logic [MCU_WIDTH_W-1:0] cfg_mcu_height;
   logic                   write_bank;
   logic                   drain_bank;
   logic [1:0]             banks_full;
   logic [3:0]             block_row;
   logic [BLOCK_COL_W-1:0] block_col;
   logic [9:0]             column_base;
   logic [13:0]            drain_index;

   strip_result_type pending_strip_results[$];
   stim_row_type     directed_rows[$];
   idle_mode_type    idle_mode;
   int               error_count;
   int               accepted_items;
   int               ignored_drains;
   int               pixels_checked;
   int               drops_checked;
   int               phase_count;

   // Clock with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int send_idle_pct();
      case (idle_mode)
         IDLE_SEND: return 87;
         IDLE_BOTH: return 35;
         default:   return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case (idle_mode)
         IDLE_RECV: return 87;
         IDLE_BOTH: return 35;
         default:   return 0;
      endcase
   endfunction

   // Apply one accepted transaction to the predicted buffer and work out its result.
   task automatic predict_strip_step(input logic cmd, input logic [PIXEL_W-1:0] pix,
                                     output bit has_res, output strip_result_type res);
      int unsigned         iw, mw, mh, col, total, idx, next_col, next_row, next_base;
      logic [STORE_AW-1:0] addr;
      logic [PIXEL_W-1:0]  word;
      iw      = clamp_size(32'(cfg_image_width), 1, MAX_WIDTH_DEF);
      mw      = clamp_size(32'(cfg_mcu_width), 1, MCU_WIDTH_MAX);
      mh      = clamp_size(32'(cfg_mcu_height), 1, MAX_BLOCK_HEIGHT_DEF);
      res     = NO_RESULT;
      has_res = 1'b0;
      if (cmd == CMD_STORE) begin
         if (banks_full >= BANKS_DEF) begin
            has_res = 1'b1;
            res     = DROP_RESULT;
         end else begin
            // Cropped columns and positions outside a shrunk block are not stored.
            col = column_base + block_col;
            if (block_row < mh && block_col < mw && col < iw) begin
               addr = STORE_AW'(write_bank * BANK_WORDS + block_row * MAX_WIDTH_DEF + col);
               strip_mem[addr] = pix;
            end
            next_col = block_col + 1;
            if (next_col >= mw) begin
               block_col = '0;
               next_row  = block_row + 1;
               if (next_row >= mh) begin
                  block_row = '0;
                  next_base = column_base + mw;
                  if (next_base >= iw) begin
                     column_base = '0;
                     banks_full  = banks_full + 2'd1;
                     write_bank  = ~write_bank;
                  end else begin
                     column_base = 10'(next_base);
                  end
               end else begin
                  block_row = 4'(next_row);
               end
            end else begin
               block_col = BLOCK_COL_W'(next_col);
            end
         end
      end else if (banks_full != 0) begin
         // A drain position beyond a shrunk strip is held at the last pixel.
         total = iw * mh;
         idx   = drain_index;
         if (idx >= total) idx = total - 1;
         addr      = STORE_AW'(drain_bank * BANK_WORDS + (idx / iw) * MAX_WIDTH_DEF +
                               (idx % iw));
         word      = strip_mem[addr];
         has_res   = 1'b1;
         res.kind  = KIND_PIXEL;
         res.red   = word[23:16];
         res.green = word[15:8];
         res.blue  = word[7:0];
         if (idx == total - 1) begin
            res.last    = 1'b1;
            drain_index = '0;
            banks_full  = banks_full - 2'd1;
            drain_bank  = ~drain_bank;
         end else begin
            drain_index = 14'(idx + 1);
         end
      end
   endtask

   // Register write, issued only once the buffer has gone quiet.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (pending_strip_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_IMAGE_WIDTH: cfg_image_width = value;
         CSR_MCU_WIDTH:   cfg_mcu_width   = value[MCU_WIDTH_W-1:0];
         CSR_MCU_HEIGHT:  cfg_mcu_height  = value[MCU_WIDTH_W-1:0];
         default: ;
      endcase
   endtask

   // Send one request transaction; starts and ends at a falling edge.
   task automatic send_item(input logic cmd, input logic [PIXEL_W-1:0] pix,
                            input row_kind_type how, input strip_result_type typed);
      bit               has_res;
      strip_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.pixel   <= pix;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_strip_step(cmd, pix, has_res, res);
      if (how == ROW_ITEM_TYPED) pending_strip_results.push_back(typed);
      else if (how == ROW_ITEM && has_res) pending_strip_results.push_back(res);
      if (cmd == CMD_DRAIN && !has_res) ignored_drains++;
      else accepted_items++;
      @(negedge clock);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] index, input int value);
      stim_row_type r;
      r.how     = ROW_CSR;
      r.index   = index;
      r.value   = CSR_DATA_W'(value);
      r.command = CMD_STORE;
      r.pixel   = '0;
      r.typed   = NO_RESULT;
      directed_rows.push_back(r);
   endtask

   task automatic add_item(input row_kind_type how, input logic cmd,
                           input logic [PIXEL_W-1:0] pix, input strip_result_type typed);
      stim_row_type r;
      r.how     = how;
      r.index   = CSR_IMAGE_WIDTH;
      r.value   = '0;
      r.command = cmd;
      r.pixel   = pix;
      r.typed   = typed;
      directed_rows.push_back(r);
   endtask

   // One phase: set the registers, then store whole strips with drains mixed in
   // until every stored strip has been read back. Drains on an empty buffer and
   // stores into two full banks are sprinkled in as noise.
   task automatic run_phase(input int iw_raw, input int mw_raw, input int mh_raw,
                            input int strips, input idle_mode_type mode);
      int unsigned        iw, mw, mh, stores_left;
      int                 store_pct;
      logic               cmd;
      logic [PIXEL_W-1:0] pix;
      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(iw_raw));
      csr_write(CSR_MCU_WIDTH, CSR_DATA_W'(mw_raw));
      csr_write(CSR_MCU_HEIGHT, CSR_DATA_W'(mh_raw));
      idle_mode   = mode;
      iw          = clamp_size(iw_raw & 'h7FF, 1, MAX_WIDTH_DEF);
      mw          = clamp_size(mw_raw & 'h1F, 1, MCU_WIDTH_MAX);
      mh          = clamp_size(mh_raw & 'h1F, 1, MAX_BLOCK_HEIGHT_DEF);
      stores_left = strips * mh * mw * ((iw + mw - 1) / mw);
      while (stores_left > 0 || banks_full != 0) begin
         if (stores_left == 0) begin
            cmd = CMD_DRAIN;
         end else begin
            if (banks_full == 0) store_pct = 95;
            else if (banks_full >= BANKS_DEF) store_pct = 10;
            else store_pct = 55;
            cmd = ($urandom_range(0, 99) < store_pct) ? CMD_STORE : CMD_DRAIN;
         end
         if (cmd == CMD_STORE && banks_full < BANKS_DEF) stores_left--;
         pix = PIXEL_W'($urandom());
         send_item(cmd, pix, ROW_ITEM, NO_RESULT);
      end
      phase_count++;
   endtask

   // Receiver side: stall at random according to the current idling pattern.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Compare every response transaction with the oldest predicted result.
   always @(posedge clock) begin : rsp_compare
      strip_result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_strip_results.size() == 0) begin
            $error("response transaction with no result pending");
            error_count++;
         end else begin
            want = pending_strip_results.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_chan.kind));
            check_field("red", want.red, rsp_chan.red);
            check_field("green", want.green, rsp_chan.green);
            check_field("blue", want.blue, rsp_chan.blue);
            check_field("last_of_strip", 8'(want.last), 8'(rsp_chan.last_of_strip));
            if (want.kind == KIND_DROP) drops_checked++;
            else pixels_checked++;
         end
      end
   end

   // Hard stop in case the buffer hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence.
   initial begin : main_flow
      int directed_count;
      int wait_cycles;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.command = CMD_STORE;
      req_chan.pixel   = '0;
      rsp_chan.ready   = 1'b1;
      cfg_image_width  = CSR_DATA_W'(IMAGE_WIDTH_RST);
      cfg_mcu_width    = MCU_WIDTH_W'(MCU_WIDTH_RST);
      cfg_mcu_height   = MCU_WIDTH_W'(MCU_HEIGHT_RST);
      write_bank       = 1'b0;
      drain_bank       = 1'b0;
      banks_full       = '0;
      block_row        = '0;
      block_col        = '0;
      column_base      = '0;
      drain_index      = '0;
      idle_mode        = IDLE_NONE;
      error_count      = 0;
      accepted_items   = 0;
      ignored_drains   = 0;
      pixels_checked   = 0;
      drops_checked    = 0;
      phase_count      = 0;

      // Directed table. A drain right after reset finds no strip.
      add_item(ROW_ITEM_NONE, CMD_DRAIN, 24'h000000, NO_RESULT);
      // One-pixel strips: fill both banks, then one more pixel is dropped.
      add_csr(CSR_IMAGE_WIDTH, 1);
      add_csr(CSR_MCU_WIDTH, 1);
      add_csr(CSR_MCU_HEIGHT, 1);
      add_item(ROW_ITEM, CMD_STORE, 24'hFFFFFF, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'h000000, NO_RESULT);
      add_item(ROW_ITEM_TYPED, CMD_STORE, 24'h123456, DROP_RESULT);
      add_item(ROW_ITEM_TYPED, CMD_DRAIN, 24'h000000,
               '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1});
      add_item(ROW_ITEM_TYPED, CMD_DRAIN, 24'hFFFFFF,
               '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1});
      add_item(ROW_ITEM_NONE, CMD_DRAIN, 24'h000000, NO_RESULT);
      // Two 2x2 blocks on a 3-wide strip: the fourth column is cropped.
      add_csr(CSR_IMAGE_WIDTH, 3);
      add_csr(CSR_MCU_WIDTH, 2);
      add_csr(CSR_MCU_HEIGHT, 2);
      add_item(ROW_ITEM, CMD_STORE, 24'hA5A5A5, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'h5A5A5A, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'h0F0F0F, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'hF0F0F0, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'h00FF00, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'h111111, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'hFF00FF, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'h222222, NO_RESULT);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);
      // Shrinking the strip mid-drain holds the position at its last pixel.
      add_csr(CSR_MCU_HEIGHT, 1);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);
      // Shrinking the block mid-block skips the stale position and wraps.
      add_csr(CSR_IMAGE_WIDTH, 2);
      add_item(ROW_ITEM, CMD_STORE, 24'h0000FF, NO_RESULT);
      add_csr(CSR_MCU_WIDTH, 1);
      add_item(ROW_ITEM, CMD_STORE, 24'h333333, NO_RESULT);
      add_item(ROW_ITEM, CMD_STORE, 24'hFF0000, NO_RESULT);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);
      add_item(ROW_ITEM, CMD_DRAIN, 24'h000000, NO_RESULT);

      // Hold reset, then release it at a falling edge.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].how == ROW_CSR) begin
            csr_write(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_item(directed_rows[i].command, directed_rows[i].pixel,
                      directed_rows[i].how, directed_rows[i].typed);
         end
      end
      directed_count = accepted_items + ignored_drains;

      // Register extremes, out-of-range values saturating, one per idling pattern.
      run_phase(0, 0, 31, 2, IDLE_NONE);
      run_phase(24, 31, 1, 2, IDLE_SEND);
      run_phase(3, 3, 16, 2, IDLE_RECV);
      run_phase(16, 1, 1, 3, IDLE_BOTH);

      // Random small settings, cycling through the idling patterns.
      while (accepted_items + ignored_drains < ITEM_TARGET || phase_count < 12) begin
         run_phase($urandom_range(1, 10), $urandom_range(0, 31), $urandom_range(0, 3),
                   $urandom_range(1, 2), idle_mode_type'(phase_count % 4));
      end
      req_chan.valid <= 1'b0;

      // Let the last results come back, then idle for the settle period.
      for (wait_cycles = 0; pending_strip_results.size() != 0 && wait_cycles < END_WAIT_MAX;
           wait_cycles++) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_strip_results.size() != 0) begin
         $error("%0d predicted results never arrived", pending_strip_results.size());
         error_count++;
      end

      $display("Covered %0d directed transactions and %0d strip phases, %0d accepted",
               directed_count, phase_count, accepted_items + ignored_drains);
      $display("Checked %0d strip pixels and %0d drops; %0d drains found no strip",
               pixels_checked, drops_checked, ignored_drains);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mtrsb_pkg.sv
rtl/mtrsb_req_if.sv
rtl/mtrsb_rsp_if.sv
rtl/mtrsb_cfg.sv
rtl/mtrsb_ctrl.sv
rtl/mtrsb_store.sv
rtl/mcu_to_raster_strip_buffer.sv
tb/testbench.sv
